[src/lac_pkg.sv]
// shared constants, payload types and helpers for the linear argmax classifier
`timescale 1ns / 1ps
`default_nettype none

package lac_pkg;

   localparam int NUM_INPUTS  = 9;
   localparam int NUM_CLASSES = 256;
   localparam int COEF_WIDTH  = 16;

   localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int PROD_W  = COEF_WIDTH + 9;
   localparam int SUM_W   = PROD_W + $clog2(NUM_INPUTS + 1);
   localparam int SCORE_W = 28;
   localparam int ACC_W   = (SUM_W > SCORE_W) ? SUM_W : SCORE_W + 1;

   localparam longint SCORE_MAX = 134217727;
   localparam longint SCORE_MIN = -134217728;

   localparam logic [CLS_W-1:0] LAST_CLS = CLS_W'(NUM_CLASSES - 1);

   localparam logic [1:0] OP_LOAD_WEIGHT = 2'd0;
   localparam logic [1:0] OP_LOAD_BIAS   = 2'd1;
   localparam logic [1:0] OP_CLASSIFY    = 2'd2;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [11:0]        table_address;
      logic signed [15:0] coef_value;
      logic [7:0]         neighbor_0;
      logic [7:0]         neighbor_1;
      logic [7:0]         neighbor_2;
      logic [7:0]         neighbor_3;
      logic [7:0]         neighbor_4;
      logic [7:0]         neighbor_5;
      logic [7:0]         neighbor_6;
      logic [7:0]         neighbor_7;
      logic [7:0]         neighbor_8;
   } req_type;

   typedef struct packed {
      logic [7:0]                best_class;
      logic signed [SCORE_W-1:0] best_score;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic             capture;
      logic             load_weight;
      logic             load_bias;
      logic             issue;
      logic             issue_first;
      logic             issue_last;
      logic [CLS_W-1:0] issue_cls;
      logic             out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic last_done;
   } ctrl_status_type;

   // sign-extend or trim the 16-bit field to the stored coefficient width
   function automatic logic signed [COEF_WIDTH-1:0] coef_fit(input logic signed [15:0] v);
      logic signed [31:0] ext;
      ext = 32'(v);
      return ext[COEF_WIDTH-1:0];
   endfunction

   function automatic logic [7:0] neighbor_at(input req_type r, input int idx);
      logic [7:0] val;
      case (idx)
         0: val = r.neighbor_0;
         1: val = r.neighbor_1;
         2: val = r.neighbor_2;
         3: val = r.neighbor_3;
         4: val = r.neighbor_4;
         5: val = r.neighbor_5;
         6: val = r.neighbor_6;
         7: val = r.neighbor_7;
         8: val = r.neighbor_8;
         default: val = 8'd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

[src/lac_datapath.sv]
// coefficient memories, multiply/sum pipeline, argmax tracker and result register
`timescale 1ns / 1ps
`default_nettype none

module lac_datapath (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire lac_pkg::req_type         req_data,
   input  wire lac_pkg::ctrl_cmd_type    cmd,
   output lac_pkg::ctrl_status_type      status,
   output lac_pkg::rsp_type              rsp_data
);
   import lac_pkg::*;

   // one weight bank per input, each holding one coefficient per class
   logic signed [COEF_WIDTH-1:0] weight_mem [NUM_INPUTS][NUM_CLASSES];
   logic signed [COEF_WIDTH-1:0] bias_mem [NUM_CLASSES];

   logic [7:0]                   x_ff [NUM_INPUTS];
   logic signed [COEF_WIDTH-1:0] coef_wr;
   logic [31:0]                  addr_ext;
   logic [NUM_INPUTS-1:0]        wr_hit;
   logic [CLS_W-1:0]             wr_row [NUM_INPUTS];
   logic                         bias_hit;

   // stage 1: rows read from memory
   logic                         s1_valid_ff, s1_first_ff, s1_last_ff;
   logic [CLS_W-1:0]             s1_cls_ff;
   logic signed [COEF_WIDTH-1:0] w_rd_ff [NUM_INPUTS];
   logic signed [COEF_WIDTH-1:0] bias_rd_ff;

   // stage 2: products
   logic                         s2_valid_ff, s2_first_ff, s2_last_ff;
   logic [CLS_W-1:0]             s2_cls_ff;
   logic signed [PROD_W-1:0]     prod_ff [NUM_INPUTS];
   logic signed [PROD_W-1:0]     prod_in [NUM_INPUTS];
   logic signed [COEF_WIDTH-1:0] s2_bias_ff;

   // stage 3: class score
   logic                         s3_valid_ff, s3_first_ff, s3_last_ff;
   logic [CLS_W-1:0]             s3_cls_ff;
   logic signed [SUM_W-1:0]      sum_ff;
   logic signed [SUM_W-1:0]      sum_in;

   logic signed [ACC_W-1:0]      sum_ext;
   logic signed [SCORE_W-1:0]    score_sat;

   logic signed [SCORE_W-1:0]    best_score_ff;
   logic [CLS_W-1:0]             best_cls_ff;
   rsp_type                      rsp_data_ff;

   assign coef_wr  = coef_fit(req_data.coef_value);
   assign addr_ext = 32'(req_data.table_address);
   assign bias_hit = addr_ext < 32'(NUM_CLASSES);

   // weight address is input * classes + class: pick the bank by range
   always_comb begin
      for (int b = 0; b < NUM_INPUTS; b++) begin
         wr_hit[b] = (addr_ext >= 32'(b * NUM_CLASSES)) &&
                     (addr_ext < 32'((b + 1) * NUM_CLASSES));
         wr_row[b] = CLS_W'(addr_ext - 32'(b * NUM_CLASSES));
      end
   end

   always_ff @(posedge clock) begin
      for (int b = 0; b < NUM_INPUTS; b++) begin
         if (cmd.load_weight && wr_hit[b]) begin
            weight_mem[b][wr_row[b]] <= coef_wr;
         end
         w_rd_ff[b] <= weight_mem[b][cmd.issue_cls];
      end
      if (cmd.load_bias && bias_hit) begin
         bias_mem[CLS_W'(addr_ext)] <= coef_wr;
      end
      bias_rd_ff <= bias_mem[cmd.issue_cls];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         for (int i = 0; i < NUM_INPUTS; i++) begin
            x_ff[i] <= neighbor_at(req_data, i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_INPUTS; i++) begin
         prod_in[i] = PROD_W'($signed({1'b0, x_ff[i]}) * w_rd_ff[i]);
      end
   end

   // bias is Q4.12, shifted into Q4.20 before the products are added
   always_comb begin
      sum_in = SUM_W'(s2_bias_ff) <<< 8;
      for (int i = 0; i < NUM_INPUTS; i++) begin
         sum_in = sum_in + SUM_W'(prod_ff[i]);
      end
   end

   assign sum_ext = ACC_W'(sum_ff);

   always_comb begin
      if (sum_ext > ACC_W'(SCORE_MAX)) begin
         score_sat = SCORE_W'(SCORE_MAX);
      end else if (sum_ext < ACC_W'(SCORE_MIN)) begin
         score_sat = SCORE_W'(SCORE_MIN);
      end else begin
         score_sat = SCORE_W'(sum_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= cmd.issue_first;
      s1_last_ff  <= cmd.issue_last;
      s1_cls_ff   <= cmd.issue_cls;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      s2_cls_ff   <= s1_cls_ff;
      s2_bias_ff  <= bias_rd_ff;
      for (int i = 0; i < NUM_INPUTS; i++) begin
         prod_ff[i] <= prod_in[i];
      end
      s3_first_ff <= s2_first_ff;
      s3_last_ff  <= s2_last_ff;
      s3_cls_ff   <= s2_cls_ff;
      sum_ff      <= sum_in;
   end

   // strict greater-than keeps the earlier class on a tie
   always_ff @(posedge clock) begin
      if (s3_valid_ff && (s3_first_ff || (score_sat > best_score_ff))) begin
         best_score_ff <= score_sat;
         best_cls_ff   <= s3_cls_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff.best_class <= 8'(best_cls_ff);
         rsp_data_ff.best_score <= best_score_ff;
      end
   end

   assign status.last_done = s3_valid_ff && s3_last_ff;
   assign rsp_data         = rsp_data_ff;

endmodule

`default_nettype wire

[src/lac_ctrl.sv]
// controller: handshakes, class sweep sequencing and result hand-off
`timescale 1ns / 1ps
`default_nettype none

module lac_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [1:0]               req_opcode,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   input  wire lac_pkg::ctrl_status_type status,
   output lac_pkg::ctrl_cmd_type         cmd
);
   import lac_pkg::*;

   state_type        state_ff, state_in;
   logic [CLS_W-1:0] cls_ff, cls_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             req_accept;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cls_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cls_ff       <= cls_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cls_in       = cls_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.issue_cls = cls_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_opcode)
                  OP_LOAD_WEIGHT: cmd.load_weight = 1'b1;
                  OP_LOAD_BIAS:   cmd.load_bias = 1'b1;
                  OP_CLASSIFY: begin
                     cmd.capture = 1'b1;
                     cls_in      = '0;
                     state_in    = ST_RUN;
                  end
                  default: ;
               endcase
            end
         end
         ST_RUN: begin
            cmd.issue       = 1'b1;
            cmd.issue_first = (cls_ff == '0);
            cmd.issue_last  = (cls_ff == LAST_CLS);
            if (cls_ff == LAST_CLS) begin
               state_in = ST_DRAIN;
            end else begin
               cls_in = cls_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (status.last_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // the previous result may still be waiting on the output side
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      status.last_done |-> (state_ff == ST_DRAIN))
      else $error("last score finished outside drain");

   a_sweep_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && cls_ff != LAST_CLS) |=> (cls_ff == $past(cls_ff) + 1'b1))
      else $error("class sweep skipped or repeated a class");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register loaded over a stalled beat");

   a_classify_starts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_opcode == OP_CLASSIFY) |=> (state_ff == ST_RUN && cls_ff == '0))
      else $error("classify beat did not start a sweep");

endmodule

`default_nettype wire

[src/linear_layer_argmax_classifier.sv]
// linear classifier top level: weight/bias loads and argmax classification
// load beats return nothing; a new beat is taken the next cycle
// a classify beat sweeps one class per cycle through the weight banks, and the
// result register is loaded once the score of the last class leaves stage 3
// the next beat is taken once the result is loaded, which waits while rsp stalls
// reset clears control state only; memories hold garbage until loaded
`timescale 1ns / 1ps
`default_nettype none

module linear_layer_argmax_classifier (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire lac_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output lac_pkg::rsp_type      rsp_data
);
   import lac_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   lac_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_data.opcode),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .status     (status),
      .cmd        (cmd)
   );

   lac_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
